>>> rtl/core/led_breathing_color_fader_top_assert.svh
// -----------------------------------------------------------------------------
// LED breathing color fader assertion macros
// Assertion macros shared by the fader RTL; they expect i_clk and i_rst_n.
// -----------------------------------------------------------------------------
`ifndef LED_BREATHING_COLOR_FADER_TOP_ASSERT_SVH
`define LED_BREATHING_COLOR_FADER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LBCF_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbcf assertion failed");
`define LBCF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) 1'b1 |-> (cond)) \
        else $error("lbcf assertion failed");
`else
`define LBCF_ASSERT_IMPLIES(label, ante, cons)
`define LBCF_ASSERT_ALWAYS(label, cond)
`endif
`endif

>>> rtl/core/lbcf_pkg.sv
// -----------------------------------------------------------------------------
// lbcf_pkg
// Types, constants and the sine table function of the breathing color fader.
// -----------------------------------------------------------------------------
package lbcf_pkg;

    localparam int PERIOD_MS_DEF  = 12000;
    localparam int SINE_STEPS_DEF = 1024;
    localparam int NUM_COLOURS    = 6;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 24;
    localparam int SINE_W         = 11;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 4'd7;

    localparam logic [23:0] PAL_RESET [NUM_COLOURS] = '{
        24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'hFF8200
    };
    localparam logic [7:0] LOW_RESET  = 8'd30;
    localparam logic [7:0] HIGH_RESET = 8'd255;

    localparam real HALF_PI = 1.5707963267948966;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_NEXT    = 2'd1,
        CMD_RESTART = 2'd2
    } t_command;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] brightness;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic sum;
        logic div_q;
        logic div_p;
        logic div_fix;
        logic scale;
        logic rom;
        logic bmul;
        logic bri;
        logic cmul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    // floor(512 * sin(ang * r)), ang = (pi/2)/n; exact at the whole-number points
    function automatic int quarter_sine(input int r, input int n, input real ang);
        real a;
        a = 512.0 * $sin(ang * real'(r));
        if (r == 0) return 0;
        if (r >= n) return 512;
        if (3 * r == n) return 256;
        return $rtoi(a);
    endfunction

    // trunc(512 * sin(2*pi*step/n))
    function automatic int sine_entry(input int step, input int n, input real ang);
        int u;
        u = 4 * step;
        if (u < n) return quarter_sine(u, n, ang);
        if (u < 2 * n) return quarter_sine(2 * n - u, n, ang);
        if (u < 3 * n) return -quarter_sine(u - 2 * n, n, ang);
        return -quarter_sine(4 * n - u, n, ang);
    endfunction

endpackage

>>> rtl/core/lbcf_ctrl.sv
// -----------------------------------------------------------------------------
// lbcf_ctrl
// Sequencer of the fader: walks one request through the datapath steps.
// -----------------------------------------------------------------------------
module lbcf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lbcf_pkg::t_dp_status i_status,
    output lbcf_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SUM   = 14'b00000000000010,
        ST_DQ0   = 14'b00000000000100,
        ST_DP0   = 14'b00000000001000,
        ST_FIX0  = 14'b00000000010000,
        ST_SCALE = 14'b00000000100000,
        ST_DQ1   = 14'b00000001000000,
        ST_DP1   = 14'b00000010000000,
        ST_FIX1  = 14'b00000100000000,
        ST_ROM   = 14'b00001000000000,
        ST_BMUL  = 14'b00010000000000,
        ST_BRI   = 14'b00100000000000,
        ST_CMUL  = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SUM;
            ST_SUM:   n_state = ST_DQ0;
            ST_DQ0:   n_state = ST_DP0;
            ST_DP0:   n_state = ST_FIX0;
            ST_FIX0:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DQ1;
            ST_DQ1:   n_state = ST_DP1;
            ST_DP1:   n_state = ST_FIX1;
            ST_FIX1:  n_state = ST_ROM;
            ST_ROM:   n_state = ST_BMUL;
            ST_BMUL:  n_state = ST_BRI;
            ST_BRI:   n_state = ST_CMUL;
            ST_CMUL:  n_state = ST_OUT;
            ST_OUT:   if (!i_status.out_busy) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_cmd.load     = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.sum      = (r_state == ST_SUM);
    assign o_cmd.div_q    = (r_state == ST_DQ0) || (r_state == ST_DQ1);
    assign o_cmd.div_p    = (r_state == ST_DP0) || (r_state == ST_DP1);
    assign o_cmd.div_fix  = (r_state == ST_FIX0) || (r_state == ST_FIX1);
    assign o_cmd.scale    = (r_state == ST_SCALE);
    assign o_cmd.rom      = (r_state == ST_ROM);
    assign o_cmd.bmul     = (r_state == ST_BMUL);
    assign o_cmd.bri      = (r_state == ST_BRI);
    assign o_cmd.cmul     = (r_state == ST_CMUL);
    assign o_cmd.out_load = (r_state == ST_OUT) && !i_status.out_busy;

endmodule

>>> rtl/core/lbcf_dp.sv
// -----------------------------------------------------------------------------
// lbcf_dp
// Datapath of the fader: config registers, phase, shared divide-by-period
// unit, sine table, brightness and color scaling, output register.
// -----------------------------------------------------------------------------
`include "led_breathing_color_fader_top_assert.svh"

module lbcf_dp #(
    parameter int PERIOD_MS  = lbcf_pkg::PERIOD_MS_DEF,
    parameter int SINE_STEPS = lbcf_pkg::SINE_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lbcf_pkg::t_dp_cmd                   i_cmd,
    output lbcf_pkg::t_dp_status                o_status,
    input  lbcf_pkg::t_in_item                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [lbcf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lbcf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lbcf_pkg::t_out_item                 o_out_data
);

    localparam int PW    = $clog2(PERIOD_MS);
    localparam int NW    = $clog2(SINE_STEPS);
    localparam int SCW   = PW + $clog2(SINE_STEPS + 1);
    localparam int SUMW  = ((PW > 16) ? PW : 16) + 1;
    localparam int XW    = (SCW > SUMW) ? SCW : SUMW;
    localparam int SW    = lbcf_pkg::SINE_W;
    localparam logic [XW-1:0] RECIP    = XW'((64'd1 << XW) / PERIOD_MS);
    localparam logic [XW-1:0] PERIOD_X = XW'(PERIOD_MS);
    localparam logic [XW-1:0] STEPS_X  = XW'(SINE_STEPS);
    localparam logic [NW-1:0] LAST_IDX = NW'(SINE_STEPS - 1);
    localparam real QTR_ANGLE = lbcf_pkg::HALF_PI / real'(SINE_STEPS);
    localparam logic [lbcf_pkg::CFG_IDX_W-1:0] CFG_COLOURS =
        lbcf_pkg::CFG_IDX_W'(lbcf_pkg::NUM_COLOURS);

    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] t;
        t = 17'(y) + 17'(y[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // control state and config
    logic [23:0]     r_pal [lbcf_pkg::NUM_COLOURS];
    logic [7:0]      r_low;
    logic [7:0]      r_high;
    logic [PW-1:0]   r_phase;
    logic [2:0]      r_sel;
    logic            r_out_valid;

    // payload
    logic [1:0]              r_cmd;
    logic [15:0]             r_elapsed;
    logic [XW-1:0]           r_x;
    logic [XW-1:0]           r_q;
    logic [XW-1:0]           r_qp;
    logic [XW-1:0]           r_rem;
    logic signed [SW-1:0]    r_sine;
    logic signed [20:0]      r_bprod;
    logic [7:0]              r_bright;
    logic [15:0]             r_pr;
    logic [15:0]             r_pg;
    logic [15:0]             r_pb;
    lbcf_pkg::t_out_item     r_out;

    logic signed [SW-1:0]    w_sine [SINE_STEPS];
    logic [2*XW-1:0]         w_qm;
    logic [XW-1:0]           w_rem;
    logic [NW-1:0]           w_idx;
    logic signed [11:0]      w_sp;
    logic signed [8:0]       w_diff;
    logic signed [20:0]      w_bq;
    logic signed [20:0]      w_bsum;
    logic [23:0]             w_colour;
    logic [2:0]              w_sel_next;

    for (genvar k = 0; k < SINE_STEPS; k++) begin : g_sine
        assign w_sine[k] = SW'(lbcf_pkg::sine_entry(k, SINE_STEPS, QTR_ANGLE));
    end

    assign w_qm       = {{XW{1'b0}}, r_x} * {{XW{1'b0}}, RECIP};
    assign w_rem      = r_x - r_qp;
    assign w_idx      = (r_q >= STEPS_X) ? LAST_IDX : r_q[NW-1:0];
    assign w_sp       = 12'(r_sine) + 12'sd512;
    assign w_diff     = $signed({1'b0, r_high}) - $signed({1'b0, r_low});
    assign w_bq       = r_bprod[20] ? ((r_bprod + 21'sd1023) >>> 10) : (r_bprod >>> 10);
    assign w_bsum     = w_bq + $signed({13'd0, r_low});
    assign w_colour   = r_pal[r_sel];
    assign w_sel_next = (r_sel >= 3'(lbcf_pkg::NUM_COLOURS - 1)) ? 3'd0 : r_sel + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal       <= lbcf_pkg::PAL_RESET;
            r_low       <= lbcf_pkg::LOW_RESET;
            r_high      <= lbcf_pkg::HIGH_RESET;
            r_phase     <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_COLOURS) begin
                    r_pal[i_cfg_idx[2:0]] <= i_cfg_data;
                end else if (i_cfg_idx == lbcf_pkg::REG_LOW_LEVEL) begin
                    r_low <= i_cfg_data[7:0];
                end else if (i_cfg_idx == lbcf_pkg::REG_HIGH_LEVEL) begin
                    r_high <= i_cfg_data[7:0];
                end
            end
            if (i_cmd.sum && (r_cmd == lbcf_pkg::CMD_NEXT)) begin
                r_sel <= w_sel_next;
            end
            if (i_cmd.scale) begin
                r_phase <= r_rem[PW-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_in_data.command;
            r_elapsed <= i_in_data.elapsed_ms;
        end
        if (i_cmd.sum) begin
            unique case (r_cmd)
                lbcf_pkg::CMD_TICK:    r_x <= XW'(r_phase) + XW'(r_elapsed);
                lbcf_pkg::CMD_RESTART: r_x <= '0;
                default:               r_x <= XW'(r_phase);
            endcase
        end
        if (i_cmd.div_q) begin
            r_q <= w_qm[2*XW-1:XW];
        end
        if (i_cmd.div_p) begin
            r_qp <= r_q * PERIOD_X;
        end
        if (i_cmd.div_fix) begin
            if (w_rem >= PERIOD_X) begin
                r_q   <= r_q + XW'(1);
                r_rem <= w_rem - PERIOD_X;
            end else begin
                r_rem <= w_rem;
            end
        end
        if (i_cmd.scale) begin
            r_x <= XW'(r_rem[PW-1:0]) * STEPS_X;
        end
        if (i_cmd.rom) begin
            r_sine <= w_sine[w_idx];
        end
        if (i_cmd.bmul) begin
            r_bprod <= 21'(w_sp) * 21'(w_diff);
        end
        if (i_cmd.bri) begin
            priority if (w_bsum < 0) begin
                r_bright <= 8'd0;
            end else if (w_bsum > 21'sd255) begin
                r_bright <= 8'd255;
            end else begin
                r_bright <= w_bsum[7:0];
            end
        end
        if (i_cmd.cmul) begin
            r_pr <= 16'(w_colour[23:16]) * 16'(r_bright);
            r_pg <= 16'(w_colour[15:8]) * 16'(r_bright);
            r_pb <= 16'(w_colour[7:0]) * 16'(r_bright);
        end
        if (i_cmd.out_load) begin
            r_out.red        <= div255(r_pr);
            r_out.green      <= div255(r_pg);
            r_out.blue       <= div255(r_pb);
            r_out.brightness <= r_bright;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    `LBCF_ASSERT_ALWAYS(a_phase_range, XW'(r_phase) < PERIOD_X)
    `LBCF_ASSERT_ALWAYS(a_sel_range, r_sel < 3'(lbcf_pkg::NUM_COLOURS))
    `LBCF_ASSERT_IMPLIES(a_step_range, i_cmd.rom, r_q < STEPS_X)

endmodule

>>> rtl/core/led_breathing_color_fader_top.sv
// A request walks SUM, DQ0, DP0, FIX0, SCALE, DQ1, DP1, FIX1, ROM, BMUL, BRI, CMUL, OUT;
// OUT loads its result into the output register. Requests are taken only in IDLE. The
// shared divide-by-period unit runs twice per request (phase wrap, then sine step).
// A waiting result does not block acceptance; the next result waits in OUT.
// Reset (synchronous, active low): phase and color index clear, registers load defaults.
// -----------------------------------------------------------------------------
// led_breathing_color_fader_top
// Breathing color fader: sine brightness over a wrapping phase times a palette color.
// -----------------------------------------------------------------------------
module led_breathing_color_fader_top #(
    parameter int PERIOD_MS  = lbcf_pkg::PERIOD_MS_DEF,
    parameter int SINE_STEPS = lbcf_pkg::SINE_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lbcf_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lbcf_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [lbcf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbcf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lbcf_pkg::t_dp_cmd    w_cmd;
    lbcf_pkg::t_dp_status w_status;

    lbcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lbcf_dp #(
        .PERIOD_MS  (PERIOD_MS),
        .SINE_STEPS (SINE_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
